// ===== sv/dlt_pkg.sv =====
// ----------------------------------------------------------------------------
// dlt_pkg: shared types and constants of the device liveness table
// request and result payloads, request codes, sequencer states and the
// fixed contents of the self record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlt_pkg;

    // request payload, one transfer on the input channel
    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        dev_id_high;
        logic [55:0]        dev_id_low;
        logic [63:0]        dev_kind_high;
        logic [55:0]        dev_kind_low;
        logic [55:0]        dev_version;
        logic signed [7:0]  signal_rssi;
        logic [3:0]         entry_index;
        logic [31:0]        now_ms;
    } t_req;

    // result payload, one transfer on the output channel
    typedef struct packed {
        logic               ok;
        logic [63:0]        rec_id_high;
        logic [55:0]        rec_id_low;
        logic [63:0]        rec_kind_high;
        logic [55:0]        rec_kind_low;
        logic [55:0]        rec_version;
        logic               rec_online;
        logic [31:0]        rec_last_seen;
        logic signed [7:0]  rec_rssi;
    } t_rsp;

    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_UPDATE   = 2'd1,
        REQ_POLL     = 2'd2,
        REQ_READ     = 2'd3
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FETCH,
        ST_DONE
    } t_state;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_TIMEOUT = 1'b0;

    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    // self record text, first character in the top byte, zero padded
    localparam logic [119:0] SELF_KEY  = 120'h73656E74696E656C_2D303100000000;
    localparam logic [119:0] SELF_KIND = 120'h6D63755F67617465_77617900000000;
    localparam logic [55:0]  SELF_VER  = 56'h322E302E300000;

endpackage

`default_nettype wire

// ===== sv/device_liveness_table_unit.sv =====
// ----------------------------------------------------------------------------
// device_liveness_table_unit: keyed device table with liveness timeout
// Keeps up to TABLE_DEPTH device records (15-character key, 15-character
// kind, 7-character version, online flag, last-seen time, signal strength),
// with the block's own record fixed in slot 0. Each request gives exactly one
// result. Register and update walk the record memory one slot per cycle to
// find the key, then write back in the write state. Poll walks the same way
// and marks stale devices offline on the fly. Read by index reads the slot
// without a walk. After each result the block returns to idle before it
// takes the next request. The walk is paced by the single read port of the
// record memory, which the one compare unit (key equality and wrapped
// elapsed time against the timeout setting) consumes at one slot per cycle.
// The input is not ready while a request is in work; a finished result sits
// in an output register, so the next request is taken while it waits. No
// clearing pass after reset: the entry count bounds every access. The
// timeout setting is at byte address 0 of the register port, reset value
// 30000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module device_liveness_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,

    // request channel
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire dlt_pkg::t_req  i_in_data,

    // result channel
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output dlt_pkg::t_rsp       o_out_data,

    // register port
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // text trim: every byte after the first zero byte reads as zero
    function automatic logic [119:0] f_trim(input logic [119:0] v);
        logic         ended;
        logic [119:0] r;
        ended = 1'b0;
        r     = '0;
        for (int k = 14; k >= 0; k--) begin
            if (v[k*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                r[k*8 +: 8] = v[k*8 +: 8];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    dlt_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;       // live entries, self included
    logic [CW-1:0]      r_ptr, n_ptr;           // memory read pointer
    logic               r_cmp_vld, n_cmp_vld;   // compare stage holds a slot
    logic [AW-1:0]      r_cmp_slot, n_cmp_slot;
    logic               r_hit, n_hit;
    logic [AW-1:0]      r_hit_slot, n_hit_slot;
    logic               r_res_ok, n_res_ok;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_timeout;

    // captured request, strings already trimmed
    dlt_pkg::t_req_kind r_req, n_req;
    logic [119:0]       r_key, n_key;
    logic [119:0]       r_kind, n_kind;
    logic [55:0]        r_ver, n_ver;
    logic signed [7:0]  r_rssi, n_rssi;
    logic [31:0]        r_now, n_now;

    // self record fields that can change (it never goes offline)
    logic [55:0]        r_self_ver, n_self_ver;
    logic [31:0]        r_self_seen, n_self_seen;
    logic signed [7:0]  r_self_rssi, n_self_rssi;

    dlt_pkg::t_rsp      r_out, n_out;

    // record memory, slot 0 unused (self record lives in registers)
    logic [119:0]       mem_key    [TABLE_DEPTH];
    logic [119:0]       mem_kind   [TABLE_DEPTH];
    logic [55:0]        mem_ver    [TABLE_DEPTH];
    logic               mem_online [TABLE_DEPTH];
    logic [31:0]        mem_seen   [TABLE_DEPTH];
    logic signed [7:0]  mem_rssi   [TABLE_DEPTH];

    logic [119:0]       r_rd_key;
    logic [119:0]       r_rd_kind;
    logic [55:0]        r_rd_ver;
    logic               r_rd_online;
    logic [31:0]        r_rd_seen;
    logic signed [7:0]  r_rd_rssi;

    // memory write port controls
    logic [AW-1:0]      wr_addr;
    logic               we_new;         // key and kind of an appended record
    logic               we_ver;
    logic               we_online;
    logic               wd_online;
    logic               we_seen;
    logic               we_rssi;
    logic signed [7:0]  wd_rssi;
    logic [AW-1:0]      rd_addr;

    // trimmed request text
    logic [119:0]       trim_key;
    logic [119:0]       trim_kind;
    logic [119:0]       trim_ver;

    // shared compare unit
    logic [119:0]       cmp_key;
    logic               key_eq;
    logic [31:0]        elapsed;
    logic               expired;
    logic               issue_more;

    logic               cfg_we;
    dlt_pkg::t_rsp      rsp;

    assign trim_key  = f_trim({i_in_data.dev_id_high, i_in_data.dev_id_low});
    assign trim_kind = f_trim({i_in_data.dev_kind_high, i_in_data.dev_kind_low});
    assign trim_ver  = f_trim({i_in_data.dev_version, 64'h0});

    assign rd_addr = r_ptr[AW-1:0];

    // one slot per cycle: key equality and wrapped elapsed time
    assign cmp_key    = (r_cmp_slot == '0) ? dlt_pkg::SELF_KEY : r_rd_key;
    assign key_eq     = (cmp_key == r_key);
    assign elapsed    = r_now - r_rd_seen;
    assign expired    = (elapsed > r_timeout);
    assign issue_more = (r_ptr < r_count);

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == dlt_pkg::CFG_IDX_TIMEOUT);
    assign prdata = (paddr[2] == dlt_pkg::CFG_IDX_TIMEOUT) ? r_timeout : 32'h0;

    // ------------------------------------------------------------------
    // result assembly: record fields only for a read with a valid index
    // ------------------------------------------------------------------
    always_comb begin
        rsp    = '0;
        rsp.ok = r_res_ok;
        if ((r_req == dlt_pkg::REQ_READ) && r_res_ok) begin
            if (r_ptr == '0) begin
                rsp.rec_id_high   = dlt_pkg::SELF_KEY[119:56];
                rsp.rec_id_low    = dlt_pkg::SELF_KEY[55:0];
                rsp.rec_kind_high = dlt_pkg::SELF_KIND[119:56];
                rsp.rec_kind_low  = dlt_pkg::SELF_KIND[55:0];
                rsp.rec_version   = r_self_ver;
                rsp.rec_online    = 1'b1;
                rsp.rec_last_seen = r_self_seen;
                rsp.rec_rssi      = r_self_rssi;
            end else begin
                rsp.rec_id_high   = r_rd_key[119:56];
                rsp.rec_id_low    = r_rd_key[55:0];
                rsp.rec_kind_high = r_rd_kind[119:56];
                rsp.rec_kind_low  = r_rd_kind[55:0];
                rsp.rec_version   = r_rd_ver;
                rsp.rec_online    = r_rd_online;
                rsp.rec_last_seen = r_rd_seen;
                rsp.rec_rssi      = r_rd_rssi;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp_vld   = 1'b0;
        n_cmp_slot  = r_cmp_slot;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_res_ok    = r_res_ok;
        n_req       = r_req;
        n_key       = r_key;
        n_kind      = r_kind;
        n_ver       = r_ver;
        n_rssi      = r_rssi;
        n_now       = r_now;
        n_self_ver  = r_self_ver;
        n_self_seen = r_self_seen;
        n_self_rssi = r_self_rssi;
        n_out       = r_out;
        // result leaves on its transfer
        n_out_valid = r_out_valid && !i_out_ready;

        o_in_ready  = 1'b0;
        wr_addr     = r_cmp_slot;
        we_new      = 1'b0;
        we_ver      = 1'b0;
        we_online   = 1'b0;
        wd_online   = 1'b1;
        we_seen     = 1'b0;
        we_rssi     = 1'b0;
        wd_rssi     = r_rssi;

        unique case (r_state)
            dlt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req  = dlt_pkg::t_req_kind'(i_in_data.req_type);
                    n_key  = trim_key;
                    n_kind = trim_kind;
                    n_ver  = trim_ver[119:64];
                    n_rssi = i_in_data.signal_rssi;
                    n_now  = i_in_data.now_ms;
                    n_hit  = 1'b0;
                    if (dlt_pkg::t_req_kind'(i_in_data.req_type) == dlt_pkg::REQ_READ) begin
                        // pointer parks on the slot so the read data stays put
                        n_ptr    = CW'(i_in_data.entry_index);
                        n_res_ok = ({28'h0, i_in_data.entry_index} < 32'(r_count));
                        n_state  = dlt_pkg::ST_FETCH;
                    end else begin
                        n_ptr   = '0;
                        n_state = dlt_pkg::ST_SCAN;
                    end
                end
            end

            dlt_pkg::ST_SCAN: begin
                // issue the next slot read
                n_cmp_vld  = issue_more;
                n_cmp_slot = r_ptr[AW-1:0];
                if (issue_more) begin
                    n_ptr = r_ptr + CW'(1);
                end
                // compare stage
                if (r_cmp_vld) begin
                    if (r_req == dlt_pkg::REQ_POLL) begin
                        if (r_cmp_slot == '0) begin
                            n_self_seen = r_now;
                        end else if (expired) begin
                            we_online = 1'b1;
                            wd_online = 1'b0;
                        end
                    end else if (key_eq) begin
                        // first match ends the walk
                        n_hit      = 1'b1;
                        n_hit_slot = r_cmp_slot;
                        n_cmp_vld  = 1'b0;
                        n_state    = dlt_pkg::ST_WRITE;
                    end
                end else if (!issue_more) begin
                    if (r_req == dlt_pkg::REQ_POLL) begin
                        n_res_ok = 1'b1;
                        n_state  = dlt_pkg::ST_DONE;
                    end else begin
                        n_state = dlt_pkg::ST_WRITE;
                    end
                end
            end

            dlt_pkg::ST_WRITE: begin
                wr_addr = r_hit_slot;
                n_state = dlt_pkg::ST_DONE;
                if (r_req == dlt_pkg::REQ_REGISTER) begin
                    if (r_hit) begin
                        n_res_ok = 1'b1;
                        if (r_hit_slot == '0) begin
                            n_self_ver  = r_ver;
                            n_self_seen = r_now;
                        end else begin
                            we_ver    = 1'b1;
                            we_online = 1'b1;
                            we_seen   = 1'b1;
                        end
                    end else if (r_count != CW'(TABLE_DEPTH)) begin
                        // append at the end of the table
                        wr_addr   = r_count[AW-1:0];
                        we_new    = 1'b1;
                        we_ver    = 1'b1;
                        we_online = 1'b1;
                        we_seen   = 1'b1;
                        we_rssi   = 1'b1;
                        wd_rssi   = '0;
                        n_count   = r_count + CW'(1);
                        n_res_ok  = 1'b1;
                    end else begin
                        n_res_ok = 1'b0;
                    end
                end else begin
                    // liveness update
                    n_res_ok = r_hit;
                    if (r_hit) begin
                        if (r_hit_slot == '0) begin
                            n_self_seen = r_now;
                            n_self_rssi = r_rssi;
                        end else begin
                            we_online = 1'b1;
                            we_seen   = 1'b1;
                            we_rssi   = 1'b1;
                        end
                    end
                end
            end

            dlt_pkg::ST_FETCH: begin
                // read data registers during this cycle
                n_state = dlt_pkg::ST_DONE;
            end

            dlt_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = rsp;
                    n_state     = dlt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = dlt_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlt_pkg::ST_IDLE;
            r_count     <= CW'(1);
            r_ptr       <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= dlt_pkg::TIMEOUT_RESET;
            r_self_ver  <= dlt_pkg::SELF_VER;
            r_self_seen <= '0;
            r_self_rssi <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_cmp_vld   <= n_cmp_vld;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_self_ver  <= n_self_ver;
            r_self_seen <= n_self_seen;
            r_self_rssi <= n_self_rssi;
            if (cfg_we) begin
                r_timeout <= pwdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_slot <= n_cmp_slot;
        r_hit_slot <= n_hit_slot;
        r_res_ok   <= n_res_ok;
        r_req      <= n_req;
        r_key      <= n_key;
        r_kind     <= n_kind;
        r_ver      <= n_ver;
        r_rssi     <= n_rssi;
        r_now      <= n_now;
        r_out      <= n_out;
    end

    // ------------------------------------------------------------------
    // record memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (we_new) begin
            mem_key[wr_addr]  <= r_key;
            mem_kind[wr_addr] <= r_kind;
        end
        if (we_ver) begin
            mem_ver[wr_addr] <= r_ver;
        end
        if (we_online) begin
            mem_online[wr_addr] <= wd_online;
        end
        if (we_seen) begin
            mem_seen[wr_addr] <= r_now;
        end
        if (we_rssi) begin
            mem_rssi[wr_addr] <= wd_rssi;
        end
        r_rd_key    <= mem_key[rd_addr];
        r_rd_kind   <= mem_kind[rd_addr];
        r_rd_ver    <= mem_ver[rd_addr];
        r_rd_online <= mem_online[rd_addr];
        r_rd_seen   <= mem_seen[rd_addr];
        r_rd_rssi   <= mem_rssi[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // the self entry is always there and the table never overfills
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(TABLE_DEPTH)))
        else $error("entry count out of range");

    // the count only grows, by one, on an append in the write-back cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (($past(r_state) == dlt_pkg::ST_WRITE) && (r_count == $past(r_count) + CW'(1))))
        else $error("entry count changed outside an append");

    // a failed request carries an all-zero record
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |->
            ((o_out_data.rec_id_high == '0) && (o_out_data.rec_last_seen == '0)
             && (o_out_data.rec_online == 1'b0)))
        else $error("record fields set on a failed request");

    // no request is taken while the compare stage is busy
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_cmp_vld)
        else $error("input ready with a slot in compare");

endmodule

`default_nettype wire

// ===== verif/device_liveness_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// device_liveness_table_unit_tb: self-checking bench for the device table
// Directed requests cover the self record, register and update with trimmed
// keys, the wrapped aging boundary and the timeout extremes. Random phases
// then run mixed requests from a small key pool under several timeouts, and
// a long receiver hold-off fills the block. Every result is compared field
// by field with an in-bench model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module device_liveness_table_unit_tb;

    localparam int          DEPTH        = 16;
    localparam int          DRAIN_CYCLES = 40;     // room for a full scan plus write-back
    localparam int          STALL_LIMIT  = 3000;   // cycles with no transfer at all
    localparam int          HOLD_CYCLES  = 300;    // receiver hold-off for the fill test
    localparam int          POOL_SIZE    = 24;
    localparam logic [2:0]  TIMEOUT_ADDR = {dlt_pkg::CFG_IDX_TIMEOUT, 2'b00};

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic           clk = 1'b0;
    logic           rst_n;

    logic           req_valid;
    logic           req_ready;
    dlt_pkg::t_req  req_data;
    logic           rsp_valid;
    logic           rsp_ready;
    dlt_pkg::t_rsp  rsp_data;

    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    device_liveness_table_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // model of the device table
    // ------------------------------------------------------------------------
    logic [119:0]       tbl_key     [DEPTH];
    logic [119:0]       tbl_kind    [DEPTH];
    logic [55:0]        tbl_ver     [DEPTH];
    logic               tbl_online  [DEPTH];
    logic [31:0]        tbl_seen    [DEPTH];
    logic signed [7:0]  tbl_rssi    [DEPTH];
    int                 dev_count;
    logic [31:0]        timeout_val;

    dlt_pkg::t_rsp      due_results [$];

    // run statistics
    int                 kind_seen   [4];
    int                 appends;
    int                 full_rejects;
    int                 update_misses;
    int                 offline_marks;
    int                 timeout_writes;
    int                 results_checked;
    int                 err_count;

    // stimulus control shared with the receiver
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    int                 rx_hold_left;
    logic [31:0]        clock_ms;
    logic [119:0]       key_pool    [POOL_SIZE];

    // drop every byte after the first zero byte of an nb-byte, top-first string
    function automatic logic [119:0] clip_text(logic [119:0] v, int nb);
        logic [119:0] r;
        bit           ended;
        int           k;
        r     = '0;
        ended = 1'b0;
        for (k = 0; k < nb; k++) begin
            if (ended || v[8*(nb-1-k) +: 8] == 8'h00)
                ended = 1'b1;
            else
                r[8*(nb-1-k) +: 8] = v[8*(nb-1-k) +: 8];
        end
        return r;
    endfunction

    // apply one request to the table and return the result it gives
    function automatic dlt_pkg::t_rsp serve_request(dlt_pkg::t_req r);
        dlt_pkg::t_rsp res;
        logic [119:0]  key;
        logic [119:0]  kind;
        logic [119:0]  ver;
        logic [31:0]   age;
        int            hit;
        int            i;
        res  = '0;
        key  = clip_text({r.dev_id_high, r.dev_id_low}, 15);
        kind = clip_text({r.dev_kind_high, r.dev_kind_low}, 15);
        ver  = clip_text({64'h0, r.dev_version}, 7);
        hit  = -1;
        kind_seen[r.req_type]++;
        if (r.req_type == dlt_pkg::REQ_REGISTER || r.req_type == dlt_pkg::REQ_UPDATE) begin
            for (i = 0; i < dev_count; i++) begin
                if (hit < 0 && tbl_key[i] == key)
                    hit = i;
            end
        end
        case (r.req_type)
            dlt_pkg::REQ_REGISTER: begin
                if (hit >= 0) begin
                    // known key keeps its kind and signal level
                    tbl_ver[hit]    = ver[55:0];
                    tbl_seen[hit]   = r.now_ms;
                    tbl_online[hit] = 1'b1;
                    res.ok          = 1'b1;
                end else if (dev_count < DEPTH) begin
                    tbl_key[dev_count]    = key;
                    tbl_kind[dev_count]   = kind;
                    tbl_ver[dev_count]    = ver[55:0];
                    tbl_online[dev_count] = 1'b1;
                    tbl_seen[dev_count]   = r.now_ms;
                    tbl_rssi[dev_count]   = 8'sd0;
                    dev_count++;
                    appends++;
                    res.ok = 1'b1;
                end else begin
                    full_rejects++;
                end
            end
            dlt_pkg::REQ_UPDATE: begin
                if (hit >= 0) begin
                    tbl_seen[hit]   = r.now_ms;
                    tbl_online[hit] = 1'b1;
                    tbl_rssi[hit]   = r.signal_rssi;
                    res.ok          = 1'b1;
                end else begin
                    update_misses++;
                end
            end
            dlt_pkg::REQ_POLL: begin
                // self record is refreshed, others age on wrapped elapsed time
                tbl_online[0] = 1'b1;
                tbl_seen[0]   = r.now_ms;
                for (i = 1; i < dev_count; i++) begin
                    age = r.now_ms - tbl_seen[i];
                    if (age > timeout_val) begin
                        if (tbl_online[i])
                            offline_marks++;
                        tbl_online[i] = 1'b0;
                    end
                end
                res.ok = 1'b1;
            end
            default: begin
                if (int'(r.entry_index) < dev_count) begin
                    res.ok            = 1'b1;
                    res.rec_id_high   = tbl_key[r.entry_index][119:56];
                    res.rec_id_low    = tbl_key[r.entry_index][55:0];
                    res.rec_kind_high = tbl_kind[r.entry_index][119:56];
                    res.rec_kind_low  = tbl_kind[r.entry_index][55:0];
                    res.rec_version   = tbl_ver[r.entry_index];
                    res.rec_online    = tbl_online[r.entry_index];
                    res.rec_last_seen = tbl_seen[r.entry_index];
                    res.rec_rssi      = tbl_rssi[r.entry_index];
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    // most gaps short, a few long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [119:0] rand_bits120();
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        return w[119:0];
    endfunction

    // random string of up to nb characters, mostly printable
    function automatic logic [119:0] rand_text(int nb);
        logic [119:0] v;
        int           len;
        int           k;
        v = '0;
        if ($urandom_range(0, 19) == 0)
            len = 0;
        else if ($urandom_range(0, 7) == 0)
            len = nb;
        else
            len = $urandom_range(1, nb);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 4) == 0)
                v[8*(nb-1-k) +: 8] = 8'($urandom_range(1, 255));
            else
                v[8*(nb-1-k) +: 8] = 8'($urandom_range(33, 126));
        end
        return v;
    endfunction

    // junk after the terminating zero, which the block has to ignore
    function automatic logic [119:0] spoil_tail(logic [119:0] v, int nb);
        bit ended;
        int k;
        ended = 1'b0;
        for (k = 0; k < nb; k++) begin
            if (ended)
                v[8*(nb-1-k) +: 8] = 8'($urandom);
            else if (v[8*(nb-1-k) +: 8] == 8'h00)
                ended = 1'b1;
        end
        return v;
    endfunction

    function automatic dlt_pkg::t_req make_req(logic [1:0] kind_code, logic [119:0] id,
                                               logic [119:0] kind, logic [55:0] ver,
                                               logic signed [7:0] rssi, logic [3:0] idx,
                                               logic [31:0] now);
        dlt_pkg::t_req r;
        r.req_type      = kind_code;
        r.dev_id_high   = id[119:56];
        r.dev_id_low    = id[55:0];
        r.dev_kind_high = kind[119:56];
        r.dev_kind_low  = kind[55:0];
        r.dev_version   = ver;
        r.signal_rssi   = rssi;
        r.entry_index   = idx;
        r.now_ms        = now;
        return r;
    endfunction

    // mixed request; key mostly from the pool so that hits and updates happen
    function automatic dlt_pkg::t_req rand_req(int unsigned step_max);
        dlt_pkg::t_req r;
        logic [119:0]  noise;
        logic [119:0]  id;
        int            pick;
        noise = rand_bits120();
        r = make_req(2'($urandom), rand_bits120(), rand_bits120(), noise[55:0],
                     8'($urandom), 4'($urandom), 32'h0);
        pick = $urandom_range(0, 99);
        if (pick < 32)
            r.req_type = dlt_pkg::REQ_REGISTER;
        else if (pick < 62)
            r.req_type = dlt_pkg::REQ_UPDATE;
        else if (pick < 75)
            r.req_type = dlt_pkg::REQ_POLL;
        else
            r.req_type = dlt_pkg::REQ_READ;
        if (r.req_type == dlt_pkg::REQ_REGISTER || r.req_type == dlt_pkg::REQ_UPDATE) begin
            if ($urandom_range(0, 99) < 85) begin
                id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 2) == 0)
                    id = spoil_tail(id, 15);
                r.dev_id_high = id[119:56];
                r.dev_id_low  = id[55:0];
            end
            if ($urandom_range(0, 9) < 7) begin
                id = spoil_tail(rand_text(15), 15);
                r.dev_kind_high = id[119:56];
                r.dev_kind_low  = id[55:0];
                id = rand_text(7);
                r.dev_version = id[55:0];
            end
        end
        // time moves forward in steps scaled to the timeout, with rare jumps
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, step_max);
        r.now_ms = clock_ms;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_req(input dlt_pkg::t_req r);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        due_results.push_back(serve_request(r));
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // timeout write followed by a read-back, block idle
    task automatic write_timeout(input logic [31:0] value);
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        timeout_val = value;
        timeout_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== value) begin
            err_count++;
            if (err_count <= 10)
                $display("ERROR timeout read-back: expected %h actual %h", value, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: receiver with random stalls and a commanded hold-off
    // ------------------------------------------------------------------------
    initial begin
        int gap_left;
        gap_left  = 0;
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rsp_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                rsp_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
                gap_left  = pick_gap() - 1;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic bit rsp_equal(dlt_pkg::t_rsp a, dlt_pkg::t_rsp b);
        return a.ok === b.ok && a.rec_id_high === b.rec_id_high &&
               a.rec_id_low === b.rec_id_low && a.rec_kind_high === b.rec_kind_high &&
               a.rec_kind_low === b.rec_kind_low && a.rec_version === b.rec_version &&
               a.rec_online === b.rec_online && a.rec_last_seen === b.rec_last_seen &&
               a.rec_rssi === b.rec_rssi;
    endfunction

    function automatic void show_rsp(string tag, dlt_pkg::t_rsp r);
        $display("  %s ok=%b id=%h_%h kind=%h_%h ver=%h on=%b seen=%h rssi=%0d",
                 tag, r.ok, r.rec_id_high, r.rec_id_low, r.rec_kind_high,
                 r.rec_kind_low, r.rec_version, r.rec_online, r.rec_last_seen,
                 r.rec_rssi);
    endfunction

    // every result transfer is checked against the oldest pending one
    dlt_pkg::t_rsp want_rsp;

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            results_checked++;
            if (due_results.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("ERROR result transfer with no request pending at %0t", $realtime);
                    show_rsp("actual  ", rsp_data);
                end
            end else begin
                want_rsp = due_results.pop_front();
                if (!rsp_equal(want_rsp, rsp_data)) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("ERROR result mismatch at %0t", $realtime);
                        show_rsp("expected", want_rsp);
                        show_rsp("actual  ", rsp_data);
                    end
                end
            end
        end
    end

    // watchdog: too long without any transfer on any port
    int quiet_cycles;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (psel && penable && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("watchdog: %0d cycles without a transfer", quiet_cycles);
                    $display("device_liveness_table_unit test failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // self record present from reset, nothing else readable
    task automatic test_reset_state();
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd0, 32'h0));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd15, 32'h0));
        send_req(make_req(dlt_pkg::REQ_POLL, '0, '0, '0, 8'sd0, 4'd0, 32'h0));
    endtask

    // append, refresh, trimmed keys, self key, all-ones and empty keys
    task automatic test_register_update();
        logic [119:0] key_a;
        logic [119:0] key_a_junk;
        logic [119:0] kind_a;
        key_a      = {"probe-a", 64'h0};
        key_a_junk = {"probe-a", 8'h00, 56'h4A554E4B4A554E};
        kind_a     = {"edge_cam", 56'h0};
        send_req(make_req(dlt_pkg::REQ_REGISTER, key_a_junk, kind_a, {"1.4", 32'h0},
                          8'sd0, 4'd0, 32'd100));
        send_req(make_req(dlt_pkg::REQ_REGISTER, key_a, {"other", 80'h0},
                          {"1.5", 8'h00, 24'h414243}, 8'sd0, 4'd0, 32'd200));
        send_req(make_req(dlt_pkg::REQ_UPDATE, key_a, '0, '0, -8'sd128, 4'd0, 32'd300));
        send_req(make_req(dlt_pkg::REQ_UPDATE, key_a_junk, '0, '0, 8'sd127, 4'd0,
                          32'd400));
        send_req(make_req(dlt_pkg::REQ_UPDATE, {"ghost", 80'h0}, '0, '0, 8'sd9, 4'd0,
                          32'd410));
        // self key: version refreshed, kind kept
        send_req(make_req(dlt_pkg::REQ_REGISTER, dlt_pkg::SELF_KEY, {"x", 8'h00, 104'h1},
                          {"3.1", 32'h0}, 8'sd0, 4'd0, 32'd500));
        send_req(make_req(dlt_pkg::REQ_REGISTER, '1, '1, '1, 8'sd0, 4'd0, 32'hFFFF_FFF0));
        send_req(make_req(dlt_pkg::REQ_REGISTER, '0, '0, '0, 8'sd0, 4'd0, 32'h0));
        send_req(make_req(dlt_pkg::REQ_UPDATE, '0, '0, '0, 8'sd5, 4'd0, 32'd7));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd0, 32'h0));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd1, 32'h0));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd2, 32'h0));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd3, 32'h0));
    endtask

    // aging exactly at the timeout, across the wrap, and at both extremes
    task automatic test_poll_aging();
        logic [119:0] key_a;
        key_a = {"probe-a", 64'h0};
        settle();
        write_timeout(32'd1000);
        send_req(make_req(dlt_pkg::REQ_POLL, '0, '0, '0, 8'sd0, 4'd0, 32'd1400));
        send_req(make_req(dlt_pkg::REQ_POLL, '0, '0, '0, 8'sd0, 4'd0, 32'd1401));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd1, 32'h0));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd2, 32'h0));
        settle();
        write_timeout(32'h0);
        send_req(make_req(dlt_pkg::REQ_REGISTER, key_a, '0, '0, 8'sd0, 4'd0, 32'd2000));
        send_req(make_req(dlt_pkg::REQ_POLL, '0, '0, '0, 8'sd0, 4'd0, 32'd2000));
        send_req(make_req(dlt_pkg::REQ_POLL, '0, '0, '0, 8'sd0, 4'd0, 32'd2001));
        settle();
        write_timeout(32'hFFFF_FFFF);
        send_req(make_req(dlt_pkg::REQ_REGISTER, key_a, '0, '0, 8'sd0, 4'd0, 32'd5));
        // elapsed wraps to all ones, which is not above the timeout
        send_req(make_req(dlt_pkg::REQ_POLL, '0, '0, '0, 8'sd0, 4'd0, 32'd4));
        send_req(make_req(dlt_pkg::REQ_READ, '0, '0, '0, 8'sd0, 4'd1, 32'h0));
    endtask

    // random phases, each under its own timeout setting
    task automatic test_random_phases();
        logic [31:0] settings [5];
        int unsigned step_max;
        int          p;
        int          n;
        key_pool[0] = dlt_pkg::SELF_KEY;
        key_pool[1] = '0;
        key_pool[2] = '1;
        for (n = 3; n < POOL_SIZE; n++)
            key_pool[n] = rand_text(15);
        settings[0] = dlt_pkg::TIMEOUT_RESET;
        settings[1] = $urandom_range(100, 3000);
        settings[2] = 32'h0;
        settings[3] = 32'hFFFF_FFFF;
        settings[4] = $urandom_range(1, 200);
        for (p = 0; p < 5; p++) begin
            settle();
            write_timeout(settings[p]);
            if (settings[p] == 0)
                step_max = 3;
            else if (settings[p] > 100000)
                step_max = 20000;
            else
                step_max = settings[p] / 3 + 1;
            // one phase runs flat out on both sides
            tx_idle_en = (p != 2);
            rx_idle_en = (p != 2);
            for (n = 0; n < 250; n++)
                send_req(rand_req(step_max));
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        settle();
        write_timeout($urandom_range(500, 5000));
        tx_idle_en   = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        for (n = 0; n < 40; n++)
            send_req(rand_req(300));
        tx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        rx_hold_left = 0;
        clock_ms     = 32'h0;
        quiet_cycles = 0;

        // table after reset: only the self record
        for (i = 0; i < DEPTH; i++) begin
            tbl_key[i]    = '0;
            tbl_kind[i]   = '0;
            tbl_ver[i]    = '0;
            tbl_online[i] = 1'b0;
            tbl_seen[i]   = '0;
            tbl_rssi[i]   = '0;
        end
        tbl_key[0]    = dlt_pkg::SELF_KEY;
        tbl_kind[0]   = dlt_pkg::SELF_KIND;
        tbl_ver[0]    = dlt_pkg::SELF_VER;
        tbl_online[0] = 1'b1;
        dev_count     = 1;
        timeout_val   = dlt_pkg::TIMEOUT_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_update();
        test_poll_aging();
        test_random_phases();
        test_backpressure();
        settle();

        $display("covered %0d register, %0d update, %0d poll, %0d read requests; %0d results",
                 kind_seen[dlt_pkg::REQ_REGISTER], kind_seen[dlt_pkg::REQ_UPDATE],
                 kind_seen[dlt_pkg::REQ_POLL], kind_seen[dlt_pkg::REQ_READ],
                 results_checked);
        $display("%0d appends, %0d full-table rejects, %0d update misses,",
                 appends, full_rejects, update_misses);
        $display("%0d offline marks, %0d timeout writes", offline_marks, timeout_writes);
        if (err_count == 0) begin
            $display("device_liveness_table_unit test passed");
        end else begin
            $display("%0d errors", err_count);
            $display("device_liveness_table_unit test failed");
        end
        $finish;
    end

endmodule
